@@ rtl/qmm_pkg.sv @@
// ----------------------------------------------------------------------------
// qmm_pkg: shared definitions of the queue with running min and max
// Sizes, command codes and the control bundle that the top level sends
// along each row of cells.
// ----------------------------------------------------------------------------
package qmm_pkg;

  // Storage geometry.
  localparam int QUEUE_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CMD_W       = 2;

  // Command codes; the unused code behaves as a report.
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NOP    = 2'd3
  } qmm_cmd_t;

  typedef logic signed [VALUE_WIDTH-1:0] qmm_val_t;

  // Control broadcast to every cell of one row.
  typedef struct packed {
    logic              enq;    // append x to this row
    logic              shift;  // drop the front entry, all cells move down
    qmm_val_t          x;      // value being appended
    logic [CNT_W-1:0]  count;  // entries held by this row before the update
  } qmm_ctl_t;

endpackage

@@ rtl/qmm_fifo_cell.sv @@
// ----------------------------------------------------------------------------
// qmm_fifo_cell: one slot of the shifting FIFO
// Slot zero always holds the oldest value. A write lands in the slot whose
// index equals the fill count; a dequeue moves every slot one place down.
// ----------------------------------------------------------------------------
module qmm_fifo_cell (
  input  logic                      clk,
  input  qmm_pkg::qmm_ctl_t         ctl,
  input  logic [qmm_pkg::IDX_W-1:0] idx,
  input  qmm_pkg::qmm_val_t         next_val,
  output qmm_pkg::qmm_val_t         val_r
);

  qmm_pkg::qmm_val_t val_nxt;
  logic              wr_here;

  // The first free slot takes the new value.
  assign wr_here = ctl.enq && ({1'b0, idx} == ctl.count);

  always_comb begin
    val_nxt = val_r;
    if (ctl.shift) begin
      val_nxt = next_val;
    end else if (wr_here) begin
      val_nxt = ctl.x;
    end
  end

  // Payload only, so no reset.
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

@@ rtl/qmm_deque_cell.sv @@
// ----------------------------------------------------------------------------
// qmm_deque_cell: one slot of a monotonic deque
// Each slot decides on its own whether it survives an enqueue. Survivors form
// a prefix, so the first slot that does not survive takes the new value and
// the slots past it fall out of the count. A front pop shifts all slots down.
// ----------------------------------------------------------------------------
module qmm_deque_cell (
  input  logic                      clk,
  input  qmm_pkg::qmm_ctl_t         ctl,
  input  logic                      is_max,
  input  logic [qmm_pkg::IDX_W-1:0] idx,
  input  logic                      prev_keep,
  input  qmm_pkg::qmm_val_t         next_val,
  output logic                      keep,
  output qmm_pkg::qmm_val_t         val_r
);

  qmm_pkg::qmm_val_t val_nxt;
  logic              held;
  logic              drop;

  // A held entry is dropped when it would break the ordering of the deque.
  assign held = {1'b0, idx} < ctl.count;
  assign drop = is_max ? (val_r < ctl.x) : (ctl.x < val_r);
  assign keep = held && !drop;

  always_comb begin
    val_nxt = val_r;
    if (ctl.shift) begin
      val_nxt = next_val;
    end else if (ctl.enq && prev_keep && !keep) begin
      val_nxt = ctl.x;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

@@ rtl/queue_with_running_min_max_unit.sv @@
// ----------------------------------------------------------------------------
// queue_with_running_min_max_unit: FIFO that reports its minimum and maximum
// Each command enqueues a signed value, dequeues the oldest one, or only
// reports. Every transfer on the input channel yields exactly one result
// on the output channel: the front, minimum and maximum after the command
// (zero when empty), the occupancy, an empty flag and an overflow flag set
// when an enqueue hit a full queue and was dropped.
// Both channels use valid and stall. At the edge of an input transfer the
// three rows of cells (FIFO, min deque, max deque) update in parallel,
// and the result is registered at that same edge, so it is offered in
// the next cycle. A new item can be taken every cycle while the receiver
// does not stall; the limit is the single compare per deque cell plus the
// count of surviving cells, all in the cycle of the transfer.
// When the receiver stalls, the result is held and the input stalls until
// it is taken; a result taken in a cycle frees room for the next input in
// that same cycle.
// Reset (synchronous, rst_n low) empties the queue and drops any pending
// result; the cell values themselves are not cleared.
// ----------------------------------------------------------------------------
module queue_with_running_min_max_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [qmm_pkg::CMD_W-1:0]         in_command,
  input  logic signed [qmm_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [qmm_pkg::VALUE_WIDTH-1:0] out_front_value,
  output logic signed [qmm_pkg::VALUE_WIDTH-1:0] out_min_value,
  output logic signed [qmm_pkg::VALUE_WIDTH-1:0] out_max_value,
  output logic                              out_is_empty,
  output logic [qmm_pkg::CNT_W-1:0]         out_occupancy,
  output logic                              out_overflow
);

  localparam int DEPTH = qmm_pkg::QUEUE_DEPTH;
  localparam int CW    = qmm_pkg::CNT_W;
  localparam int IW    = qmm_pkg::IDX_W;

  logic                   in_xfer;
  logic                   out_xfer;
  logic                   is_enq;
  logic                   is_deq;
  logic                   do_enq;
  logic                   do_deq;
  logic                   ovf;
  logic                   pop_min;
  logic                   pop_max;

  logic [CW-1:0]          fifo_cnt_r, fifo_cnt_nxt;
  logic [CW-1:0]          min_cnt_r, min_cnt_nxt;
  logic [CW-1:0]          max_cnt_r, max_cnt_nxt;
  logic [CW-1:0]          min_kept;
  logic [CW-1:0]          max_kept;

  qmm_pkg::qmm_ctl_t      fifo_ctl;
  qmm_pkg::qmm_ctl_t      min_ctl;
  qmm_pkg::qmm_ctl_t      max_ctl;

  qmm_pkg::qmm_val_t      fifo_val [DEPTH];
  qmm_pkg::qmm_val_t      min_val  [DEPTH];
  qmm_pkg::qmm_val_t      max_val  [DEPTH];
  logic [DEPTH-1:0]       min_keep;
  logic [DEPTH-1:0]       max_keep;

  qmm_pkg::qmm_val_t      front_nxt;
  qmm_pkg::qmm_val_t      minv_nxt;
  qmm_pkg::qmm_val_t      maxv_nxt;

  logic                   out_valid_r;
  qmm_pkg::qmm_val_t      front_r;
  qmm_pkg::qmm_val_t      minv_r;
  qmm_pkg::qmm_val_t      maxv_r;
  logic                   empty_r;
  logic [CW-1:0]          occ_r;
  logic                   ovf_r;

  // Handshake: the output register frees room when its result is taken.
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  // Command decode; the unused code acts as a report.
  assign is_enq = in_command == qmm_pkg::CMD_ENQ;
  assign is_deq = in_command == qmm_pkg::CMD_DEQ;
  assign ovf    = in_xfer && is_enq && (fifo_cnt_r == CW'(DEPTH));
  assign do_enq = in_xfer && is_enq && (fifo_cnt_r != CW'(DEPTH));
  assign do_deq = in_xfer && is_deq && (fifo_cnt_r != '0);

  // A deque front leaves along with the FIFO head it equals.
  assign pop_min = do_deq && (min_cnt_r != '0) && (min_val[0] == fifo_val[0]);
  assign pop_max = do_deq && (max_cnt_r != '0) && (max_val[0] == fifo_val[0]);

  // Control bundles for the three rows.
  assign fifo_ctl = '{enq: do_enq, shift: do_deq, x: in_value, count: fifo_cnt_r};
  assign min_ctl  = '{enq: do_enq, shift: pop_min, x: in_value, count: min_cnt_r};
  assign max_ctl  = '{enq: do_enq, shift: pop_max, x: in_value, count: max_cnt_r};

  // Rows of cells; the last cell shifts in its own value, which then lies
  // past the count and is never read.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    qmm_fifo_cell u_fifo (
      .clk      (clk),
      .ctl      (fifo_ctl),
      .idx      (IW'(i)),
      .next_val ((i == DEPTH - 1) ? fifo_val[i] : fifo_val[(i + 1) % DEPTH]),
      .val_r    (fifo_val[i])
    );

    qmm_deque_cell u_min (
      .clk       (clk),
      .ctl       (min_ctl),
      .is_max    (1'b0),
      .idx       (IW'(i)),
      .prev_keep ((i == 0) ? 1'b1 : min_keep[(i + DEPTH - 1) % DEPTH]),
      .next_val  ((i == DEPTH - 1) ? min_val[i] : min_val[(i + 1) % DEPTH]),
      .keep      (min_keep[i]),
      .val_r     (min_val[i])
    );

    qmm_deque_cell u_max (
      .clk       (clk),
      .ctl       (max_ctl),
      .is_max    (1'b1),
      .idx       (IW'(i)),
      .prev_keep ((i == 0) ? 1'b1 : max_keep[(i + DEPTH - 1) % DEPTH]),
      .next_val  ((i == DEPTH - 1) ? max_val[i] : max_val[(i + 1) % DEPTH]),
      .keep      (max_keep[i]),
      .val_r     (max_val[i])
    );
  end

  // Survivors of an enqueue form a prefix, so the last surviving cell gives
  // the new length before the append.
  always_comb begin
    min_kept = '0;
    max_kept = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (min_keep[i]) begin
        min_kept = CW'(i + 1);
      end
      if (max_keep[i]) begin
        max_kept = CW'(i + 1);
      end
    end
  end

  // Next fill counts.
  always_comb begin
    fifo_cnt_nxt = fifo_cnt_r;
    min_cnt_nxt  = min_cnt_r;
    max_cnt_nxt  = max_cnt_r;
    if (do_enq) begin
      fifo_cnt_nxt = fifo_cnt_r + CW'(1);
      min_cnt_nxt  = min_kept + CW'(1);
      max_cnt_nxt  = max_kept + CW'(1);
    end else begin
      if (do_deq) begin
        fifo_cnt_nxt = fifo_cnt_r - CW'(1);
      end
      if (pop_min) begin
        min_cnt_nxt = min_cnt_r - CW'(1);
      end
      if (pop_max) begin
        max_cnt_nxt = max_cnt_r - CW'(1);
      end
    end
  end

  // Front, minimum and maximum as they stand after the command.
  always_comb begin
    front_nxt = fifo_val[0];
    minv_nxt  = min_val[0];
    maxv_nxt  = max_val[0];
    if (do_enq) begin
      if (fifo_cnt_r == '0) begin
        front_nxt = in_value;
      end
      if (!min_keep[0]) begin
        minv_nxt = in_value;
      end
      if (!max_keep[0]) begin
        maxv_nxt = in_value;
      end
    end else begin
      if (do_deq) begin
        front_nxt = fifo_val[1 % DEPTH];
      end
      if (pop_min) begin
        minv_nxt = min_val[1 % DEPTH];
      end
      if (pop_max) begin
        maxv_nxt = max_val[1 % DEPTH];
      end
    end
    if (fifo_cnt_nxt == '0) begin
      front_nxt = '0;
      minv_nxt  = '0;
      maxv_nxt  = '0;
    end
  end

  // Control state: fill counts and the result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_cnt_r  <= '0;
      min_cnt_r   <= '0;
      max_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fifo_cnt_r <= fifo_cnt_nxt;
      min_cnt_r  <= min_cnt_nxt;
      max_cnt_r  <= max_cnt_nxt;
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register, loaded at each input transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      front_r <= front_nxt;
      minv_r  <= minv_nxt;
      maxv_r  <= maxv_nxt;
      empty_r <= fifo_cnt_nxt == '0;
      occ_r   <= fifo_cnt_nxt;
      ovf_r   <= ovf;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_value = front_r;
  assign out_min_value   = minv_r;
  assign out_max_value   = maxv_r;
  assign out_is_empty    = empty_r;
  assign out_occupancy   = occ_r;
  assign out_overflow    = ovf_r;

endmodule
